>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bev_pkg;

  // image geometry
  localparam int OUT_HEIGHT = 512;
  localparam int OUT_WIDTH  = 512;
  localparam int SRC_HEIGHT = 1024;
  localparam int SRC_WIDTH  = 1024;

  // datapath widths
  localparam int COEF_W = 32;
  localparam int CRD_W  = 9;
  localparam int QBITS  = 10;
  localparam int CMP_W  = 13;
  localparam int PROD_W = COEF_W + CRD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DEN_W  = SUM_W + 1;
  localparam int REM_W  = DEN_W + QBITS;
  localparam int Q_ONE  = 65536;
  localparam int DIV_STAGES = QBITS / 2;

  typedef enum logic [2:0] {
    REG_U_COL,
    REG_U_ROW,
    REG_U_CONST,
    REG_V_COL,
    REG_V_ROW,
    REG_V_CONST,
    REG_W_COL,
    REG_W_ROW
  } reg_idx_t;

  typedef struct packed {
    logic [CRD_W-1:0] out_row;
    logic [CRD_W-1:0] out_col;
  } in_t;

  typedef struct packed {
    logic [QBITS-1:0] src_row;
    logic [QBITS-1:0] src_col;
    logic             in_range;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] u_col;
    logic signed [COEF_W-1:0] u_row;
    logic signed [COEF_W-1:0] u_const;
    logic signed [COEF_W-1:0] v_col;
    logic signed [COEF_W-1:0] v_row;
    logic signed [COEF_W-1:0] v_const;
    logic signed [COEF_W-1:0] w_col;
    logic signed [COEF_W-1:0] w_row;
  } coef_t;

  // one item in flight through the divider stages
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [REM_W-1:0] rem_u;
    logic [REM_W-1:0] rem_v;
    logic [DEN_W-1:0] den;
    logic [QBITS-1:0] q_u;
    logic [QBITS-1:0] q_v;
  } div_t;

endpackage

`default_nettype wire

>>> rtl/bev_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bev_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire bev_pkg::in_t   in_data,
  input  wire bev_pkg::coef_t coef,
  output bev_pkg::div_t       dout
);

  localparam int PW = bev_pkg::PROD_W;
  localparam int SW = bev_pkg::SUM_W;
  localparam int DW = bev_pkg::DEN_W;
  localparam int RW = bev_pkg::REM_W;
  localparam int CW = bev_pkg::CMP_W;
  localparam logic signed [SW-1:0] Q_ONE_C = SW'(bev_pkg::Q_ONE);

  // stage 1: products
  logic                 v1_r, bad1_r;
  logic signed [PW-1:0] puc_r, pur_r, pvc_r, pvr_r, pwc_r, pwr_r;
  logic signed [bev_pkg::CRD_W:0] col_s, row_s;
  logic                 bad_nxt;

  // stage 2: numerators and denominator
  logic                 v2_r, bad2_r;
  logic signed [SW-1:0] un_r, vn_r, wn_r;

  // stage 3: sign folding
  logic                 v3_r, ok3_r;
  logic [DW-1:0]        nu3_r, nv3_r, den3_r;
  logic signed [DW-1:0] nu_s, nv_s, den_s;
  logic                 ok3_nxt;

  // stage 4: range bound
  logic [RW-1:0]        lim_u, lim_v;

  assign col_s = signed'({1'b0, in_data.out_col});
  assign row_s = signed'({1'b0, in_data.out_row});
  assign bad_nxt = (CW'(in_data.out_row) >= CW'(bev_pkg::OUT_HEIGHT)) ||
                   (CW'(in_data.out_col) >= CW'(bev_pkg::OUT_WIDTH));

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      bad1_r <= bad_nxt;
      puc_r  <= PW'(coef.u_col * col_s);
      pur_r  <= PW'(coef.u_row * row_s);
      pvc_r  <= PW'(coef.v_col * col_s);
      pvr_r  <= PW'(coef.v_row * row_s);
      pwc_r  <= PW'(coef.w_col * col_s);
      pwr_r  <= PW'(coef.w_row * row_s);
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      bad2_r <= bad1_r;
      un_r   <= SW'(puc_r) + SW'(pur_r) + SW'(coef.u_const);
      vn_r   <= SW'(pvc_r) + SW'(pvr_r) + SW'(coef.v_const);
      wn_r   <= SW'(pwc_r) + SW'(pwr_r) + SW'(signed'(Q_ONE_C));
    end
  end

  // fold denominator sign into the numerators
  always_comb begin
    den_s = DW'(wn_r);
    nu_s  = DW'(un_r);
    nv_s  = DW'(vn_r);
    if (wn_r[SW-1]) begin
      den_s = -den_s;
      nu_s  = -nu_s;
      nv_s  = -nv_s;
    end
    ok3_nxt = !bad2_r && (wn_r != '0) && !nu_s[DW-1] && !nv_s[DW-1];
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      ok3_r  <= ok3_nxt;
      nu3_r  <= nu_s;
      nv3_r  <= nv_s;
      den3_r <= den_s;
    end
  end

  // ratio at most limit-1 exactly when n <= (limit-1) * w
  assign lim_u = RW'(den3_r) * RW'(bev_pkg::SRC_WIDTH - 1);
  assign lim_v = RW'(den3_r) * RW'(bev_pkg::SRC_HEIGHT - 1);

  // stage 4 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v3_r;
    end
    if (en) begin
      dout.ok    <= ok3_r && (RW'(nu3_r) <= lim_u) && (RW'(nv3_r) <= lim_v);
      dout.rem_u <= RW'(nu3_r);
      dout.rem_v <= RW'(nv3_r);
      dout.den   <= den3_r;
      dout.q_u   <= '0;
      dout.q_v   <= '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bev_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module bev_div_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [3:0]    sh,
  input  wire bev_pkg::div_t din,
  output bev_pkg::div_t      dout
);

  localparam int RW = bev_pkg::REM_W;

  bev_pkg::div_t  step_nxt;
  logic [RW-1:0]  dsh;
  logic [3:0]     bit_idx;

  // two restoring steps, high quotient bit first
  always_comb begin
    step_nxt = din;
    dsh      = '0;
    bit_idx  = '0;
    for (int j = 1; j >= 0; j--) begin
      bit_idx = sh + 4'(j);
      dsh     = RW'(din.den) << bit_idx;
      if (step_nxt.rem_u >= dsh) begin
        step_nxt.rem_u          = step_nxt.rem_u - dsh;
        step_nxt.q_u[bit_idx]   = 1'b1;
      end
      if (step_nxt.rem_v >= dsh) begin
        step_nxt.rem_v          = step_nxt.rem_v - dsh;
        step_nxt.q_v[bit_idx]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= step_nxt.valid;
    end
    if (en) begin
      dout.ok    <= step_nxt.ok;
      dout.rem_u <= step_nxt.rem_u;
      dout.rem_v <= step_nxt.rem_v;
      dout.den   <= step_nxt.den;
      dout.q_u   <= step_nxt.q_u;
      dout.q_v   <= step_nxt.q_v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/birds_eye_view_source_address_unit.sv
// Bird's-eye view source address unit.
// Input channel (in_valid, in_ready, in_data) carries one output pixel
// coordinate; the result channel (out_valid, out_ready, out_data) returns the
// source pixel to copy and an in_range flag. When in_range is low the
// address fields are zero and the caller writes black.
// Eight Q16.16 homography coefficients are written through cfg_we, cfg_idx
// and cfg_wdata, one register per cycle; the user must write them only while
// no transfer is in flight, as the block does not enforce this. 4 stages form
// products, sums, sign folding and the range bound, 5 stages of the restoring
// divider each resolve two quotient bits of u/w and v/w, and one output
// register holds the result. Throughput is one transfer per cycle while the
// output is not blocked; the whole pipeline advances together. When out_ready
// is low while a result waits, every stage holds and in_ready drops in the
// same cycle, so nothing is lost or repeated. Synchronous reset clears all
// valid bits and restores the coefficients to the identity mapping.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module birds_eye_view_source_address_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bev_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bev_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_wdata
);

  localparam int NS = bev_pkg::DIV_STAGES;

  bev_pkg::coef_t coef_r;
  bev_pkg::div_t  div_s [0:NS];
  logic           en;
  logic           out_valid_r;
  bev_pkg::out_t  out_data_r;

  // whole pipeline moves unless a result is stuck at the output
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{u_col: 32'(bev_pkg::Q_ONE), v_row: 32'(bev_pkg::Q_ONE), default: '0};
    end else if (cfg_we) begin
      unique case (bev_pkg::reg_idx_t'(cfg_idx))
        bev_pkg::REG_U_COL:   coef_r.u_col   <= cfg_wdata;
        bev_pkg::REG_U_ROW:   coef_r.u_row   <= cfg_wdata;
        bev_pkg::REG_U_CONST: coef_r.u_const <= cfg_wdata;
        bev_pkg::REG_V_COL:   coef_r.v_col   <= cfg_wdata;
        bev_pkg::REG_V_ROW:   coef_r.v_row   <= cfg_wdata;
        bev_pkg::REG_V_CONST: coef_r.v_const <= cfg_wdata;
        bev_pkg::REG_W_COL:   coef_r.w_col   <= cfg_wdata;
        bev_pkg::REG_W_ROW:   coef_r.w_row   <= cfg_wdata;
        default:              coef_r         <= coef_r;
      endcase
    end
  end

  // numerators, denominator and range bound
  bev_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .coef     (coef_r),
    .dout     (div_s[0])
  );

  // divider, two quotient bits per stage
  for (genvar i = 0; i < NS; i++) begin : g_div
    bev_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sh    (4'(bev_pkg::QBITS - 2 - 2 * i)),
      .din   (div_s[i]),
      .dout  (div_s[i+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_s[NS].valid;
    end
    if (en) begin
      out_data_r.in_range <= div_s[NS].ok;
      out_data_r.src_row  <= div_s[NS].ok ? div_s[NS].q_v : '0;
      out_data_r.src_col  <= div_s[NS].ok ? div_s[NS].q_u : '0;
    end
  end

  `ASSERT_CLK(a_oor_zero, clk, rst_n, out_valid && !out_data.in_range |-> out_data.src_row == '0 && out_data.src_col == '0, "out of range result carries an address")
  `ASSERT_CLK(a_stall_only_when_blocked, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without a blocked output")
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_valid, "result valid right after reset")

endmodule

`default_nettype wire
